// File: src/depth_background_labeler_top_macros.svh
// Assertion macros used by the top-level RTL file of the depth background labeler.
// The enclosing module must have a clock named clk and an active-low reset named rst_n.
`ifndef DEPTH_BACKGROUND_LABELER_TOP_MACROS_SVH
`define DEPTH_BACKGROUND_LABELER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define DBL_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

`define DBL_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define DBL_ASSERT_IMP(name, ante, cons)

`define DBL_ASSERT_NXT(name, ante, cons)

`endif

`endif

// File: src/dbl_pkg.sv
`default_nettype none

package dbl_pkg;

  localparam int FRAME_PIXELS = 307200;
  localparam int PIX_AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  localparam int IDX_W = 19;
  localparam int DEPTH_W = 16;
  localparam int CNT_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [DEPTH_W-1:0] BG_RESET_MM = 16'd100;
  localparam logic [CNT_W-1:0] CNT_MAX = 4'hF;

  localparam logic [DEPTH_W-1:0] NEAR_RESET = 16'd400;
  localparam logic [DEPTH_W-1:0] FAR_RESET = 16'hFFFF;
  localparam logic [DEPTH_W-1:0] THR_RESET = 16'd50;
  localparam logic [CNT_W-1:0] STABLE_RESET = 4'd5;

  typedef enum logic [1:0] {
    LBL_UNEXPLAINED = 2'd0,
    LBL_NOSIGNAL    = 2'd1,
    LBL_TOOFAR      = 2'd2,
    LBL_BACKGROUND  = 2'd3
  } label_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR   = 3'd0,
    CFG_FAR    = 3'd1,
    CFG_THR    = 3'd2,
    CFG_UPD_EN = 3'd3,
    CFG_STABLE = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] near_limit;
    logic [DEPTH_W-1:0] far_limit;
    logic [DEPTH_W-1:0] fg_threshold;
    logic               update_enable;
    logic [CNT_W-1:0]   stable_limit;
  } cfg_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] bg;
    logic [CNT_W-1:0]   cnt;
    logic [DEPTH_W-1:0] min_depth;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{bg: BG_RESET_MM, cnt: '0, min_depth: '0};

endpackage

`default_nettype wire

// File: src/depth_background_labeler_top.sv
`default_nettype none

// Labels one depth pixel per clock unless the output stalls, and adapts a per-pixel
// background model held in one 36-bit wide memory of FRAME_PIXELS (307200) entries with
// one write and one registered read port. A transfer on the input channel reads the
// pixel's entry; when stage 1 advances it is updated, written back if the pixel is in
// range, updates are enabled and it is not labelled no-signal, and the output register is loaded.
// Back-to-back pixels with the same index are served by forwarding the entry just
// written. After reset the block initializes the memory, one entry per cycle, and holds
// in_ready low until that is done; configuration writes are taken at any time.
module depth_background_labeler_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [dbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dbl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dbl_pkg::IDX_W-1:0]     in_pixel_index,
  input  wire logic [dbl_pkg::DEPTH_W-1:0]   in_depth_mm,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_label,
  output logic [dbl_pkg::DEPTH_W-1:0]        out_background_mm
);
  import dbl_pkg::*;

  `include "depth_background_labeler_top_macros.svh"

  cfg_t cfg_r;

  logic              clr_busy_r;
  logic [PIX_AW-1:0] clr_addr_r;

  logic               s1_v_r;
  logic [PIX_AW-1:0]  s1_addr_r;
  logic               s1_in_range_r;
  logic [DEPTH_W-1:0] s1_depth_r;
  logic               fwd_hit_r;
  entry_t             fwd_data_r;

  logic               out_v_r;
  label_t             out_label_r;
  logic [DEPTH_W-1:0] out_bg_r;

  logic               in_acc;
  logic               s1_adv;
  logic [PIX_AW-1:0]  in_addr;
  logic               in_range;

  logic               ram_we;
  logic [PIX_AW-1:0]  ram_waddr;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  entry_t             s1_entry;
  label_t             upd_label;
  logic [DEPTH_W-1:0] upd_bg;
  logic               upd_we;
  entry_t             upd_entry;
  logic               pipe_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_limit <= NEAR_RESET;
      cfg_r.far_limit <= FAR_RESET;
      cfg_r.fg_threshold <= THR_RESET;
      cfg_r.update_enable <= 1'b1;
      cfg_r.stable_limit <= STABLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NEAR:   cfg_r.near_limit <= cfg_wdata;
        CFG_FAR:    cfg_r.far_limit <= cfg_wdata;
        CFG_THR:    cfg_r.fg_threshold <= cfg_wdata;
        CFG_UPD_EN: cfg_r.update_enable <= cfg_wdata[0];
        CFG_STABLE: cfg_r.stable_limit <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == PIX_AW'(FRAME_PIXELS - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= PIX_AW'(clr_addr_r + PIX_AW'(1));
    end
  end

  assign s1_adv = !out_v_r || out_ready;
  assign in_ready = !clr_busy_r && (!s1_v_r || s1_adv);
  assign in_acc = in_valid && in_ready;
  assign in_addr = PIX_AW'(in_pixel_index);
  assign in_range = 32'(in_pixel_index) < FRAME_PIXELS;

  assign pipe_we = s1_v_r && s1_adv && upd_we;
  assign ram_we = clr_busy_r || pipe_we;
  assign ram_waddr = clr_busy_r ? clr_addr_r : s1_addr_r;
  assign ram_wdata = clr_busy_r ? ENTRY_RESET : upd_entry;

  dbl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(FRAME_PIXELS),
    .AW(PIX_AW)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(in_acc),
    .raddr(in_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_acc) begin
      fwd_hit_r <= ram_we && (ram_waddr == in_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr_r <= in_addr;
      s1_in_range_r <= in_range;
      s1_depth_r <= in_depth_mm;
      fwd_data_r <= ram_wdata;
    end
  end

  assign s1_entry = fwd_hit_r ? fwd_data_r : entry_t'(ram_rdata);

  dbl_update u_update (
    .cfg(cfg_r),
    .depth(s1_depth_r),
    .in_range(s1_in_range_r),
    .entry(s1_entry),
    .label(upd_label),
    .bg_out(upd_bg),
    .we(upd_we),
    .entry_nxt(upd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_v_r) begin
      out_label_r <= upd_label;
      out_bg_r <= upd_bg;
    end
  end

  assign out_valid = out_v_r;
  assign out_label = out_label_r;
  assign out_background_mm = out_bg_r;

  `DBL_ASSERT_IMP(a_no_update_during_clear, clr_busy_r, !pipe_we)
  `DBL_ASSERT_IMP(a_write_only_on_advance, pipe_we, s1_v_r && s1_adv && s1_in_range_r)
  `DBL_ASSERT_NXT(a_forward_on_same_pixel, in_acc && pipe_we && (s1_addr_r == in_addr), fwd_hit_r)
  `DBL_ASSERT_NXT(a_clear_ends, clr_busy_r && (clr_addr_r == PIX_AW'(FRAME_PIXELS - 1)), !clr_busy_r)

endmodule

`default_nettype wire

// File: src/dbl_ram.sv
`default_nettype none

module dbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: src/dbl_update.sv
`default_nettype none

module dbl_update (
  input  wire dbl_pkg::cfg_t           cfg,
  input  wire logic [dbl_pkg::DEPTH_W-1:0] depth,
  input  wire logic                    in_range,
  input  wire dbl_pkg::entry_t         entry,
  output dbl_pkg::label_t              label,
  output logic [dbl_pkg::DEPTH_W-1:0]  bg_out,
  output logic                         we,
  output dbl_pkg::entry_t              entry_nxt
);
  import dbl_pkg::*;

  logic             no_signal;
  logic             too_far;
  label_t           base_label;
  logic             upd;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] cnt_n;
  logic [DEPTH_W-1:0] min_n;
  logic [DEPTH_W-1:0] bg_n;
  logic [DEPTH_W-1:0] bg_eff;
  logic signed [DEPTH_W+1:0] bg_margin;
  logic signed [DEPTH_W+1:0] depth_s;

  always_comb begin
    no_signal = (depth < cfg.near_limit) || (depth == '0);
    too_far = depth > cfg.far_limit;
    priority if (too_far) begin
      base_label = LBL_TOOFAR;
    end else if (no_signal) begin
      base_label = LBL_NOSIGNAL;
    end else begin
      base_label = LBL_UNEXPLAINED;
    end

    upd = cfg.update_enable && (base_label != LBL_NOSIGNAL);
    lim = (cfg.stable_limit == '0) ? CNT_W'(1) : cfg.stable_limit;

    min_n = entry.min_depth;
    bg_n = entry.bg;
    if (depth > entry.bg) begin
      if ((entry.cnt == '0) || (entry.min_depth > depth)) begin
        min_n = depth;
      end
      cnt_n = (entry.cnt != CNT_MAX) ? CNT_W'(entry.cnt + CNT_W'(1)) : CNT_MAX;
    end else begin
      cnt_n = '0;
    end
    if (cnt_n >= lim) begin
      bg_n = min_n;
      cnt_n = '0;
    end

    entry_nxt.bg = bg_n;
    entry_nxt.cnt = cnt_n;
    entry_nxt.min_depth = min_n;

    we = in_range && upd;
    bg_eff = upd ? bg_n : entry.bg;

    depth_s = $signed({2'b00, depth});
    bg_margin = $signed({2'b00, bg_eff}) - $signed({2'b00, cfg.fg_threshold});

    label = base_label;
    if (in_range && (base_label == LBL_UNEXPLAINED) && (depth_s > bg_margin)) begin
      label = LBL_BACKGROUND;
    end
    bg_out = in_range ? bg_eff : '0;
  end

endmodule

`default_nettype wire
